// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands shared by the pulse-distance decoder RTL.
// No dependencies; pulled in by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/core/pdfd_pkg.sv -----
// Shared types, constants and helpers for the pulse-distance frame decoder.
// No dependencies; imported by every module of the block.
package pdfd_pkg;

  localparam int FRAME_BYTES_DEF = 9;
  localparam int RING_SLOTS_DEF  = 5;
  localparam int CMD_DEPTH       = 4;
  localparam int OUT_DEPTH       = 4;

  localparam int DUR_W     = 15;
  localparam int LEN_W     = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RX_SPACE_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADING_SPACE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_ONE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_ZERO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_TOL      = 3'd4;

  localparam logic             RST_RX_SPACE_LEVEL = 1'b1;
  localparam logic [DUR_W-1:0] RST_LEADING_SPACE  = 15'd4000;
  localparam logic [DUR_W-1:0] RST_SPACE_ONE      = 15'd1500;
  localparam logic [DUR_W-1:0] RST_SPACE_ZERO     = 15'd500;
  localparam logic [DUR_W-1:0] RST_NOISE_TOL      = 15'd300;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic             first_of_capture;
    logic [LEN_W-1:0] capture_length;
    logic             level_a;
    logic [DUR_W-1:0] duration_a;
    logic             level_b;
    logic [DUR_W-1:0] duration_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_available;
    logic       last_byte;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic is_read;
    logic first;
    logic len_ok;
    logic has_bit;
    logic bit_val;
  } cmd_t;

  function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/pdfd_fifo.sv -----
// Small register FIFO used for the command queue and the result queue.
// Depends on assert_macros.svh and pdfd_pkg.
`include "assert_macros.svh"

module pdfd_fifo
  import pdfd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_count_grows, clk, rst, do_wr && !do_rd, count == $past(count) + 1'b1)

endmodule

// ----- rtl/core/pdfd_front.sv -----
// Front end: timing registers and per-item space classification.
// Depends on pdfd_pkg.
module pdfd_front
  import pdfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data,
  input  in_item_t             item,
  output cmd_t                 cmd
);

  logic             rx_space_level;
  logic [DUR_W-1:0] leading_space_us;
  logic [DUR_W-1:0] space_one_us;
  logic [DUR_W-1:0] space_zero_us;
  logic [DUR_W-1:0] noise_tolerance_us;

  logic             space_found;
  logic [DUR_W-1:0] space_dur;
  logic             in_lead;
  logic             near_one;
  logic             near_zero;

  // |d - nominal| < tol, on 16-bit signed differences
  function automatic logic near(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] nom,
                                input logic [DUR_W-1:0] tol);
    logic signed [DUR_W:0] diff;
    logic        [DUR_W:0] mag;
    diff = $signed({1'b0, d}) - $signed({1'b0, nom});
    mag  = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);
    return mag < {1'b0, tol};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_space_level     <= RST_RX_SPACE_LEVEL;
      leading_space_us   <= RST_LEADING_SPACE;
      space_one_us       <= RST_SPACE_ONE;
      space_zero_us      <= RST_SPACE_ZERO;
      noise_tolerance_us <= RST_NOISE_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RX_SPACE_LEVEL: rx_space_level     <= cfg_data[0];
        REG_LEADING_SPACE:  leading_space_us   <= cfg_data;
        REG_SPACE_ONE:      space_one_us       <= cfg_data;
        REG_SPACE_ZERO:     space_zero_us      <= cfg_data;
        REG_NOISE_TOL:      noise_tolerance_us <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    space_found = 1'b1;
    space_dur   = item.duration_a;
    if (item.level_a == rx_space_level) begin
      space_dur = item.duration_a;
    end else if (item.level_b == rx_space_level) begin
      space_dur = item.duration_b;
    end else begin
      space_found = 1'b0;
    end
    in_lead   = near(space_dur, leading_space_us, noise_tolerance_us);
    near_one  = near(space_dur, space_one_us, noise_tolerance_us);
    near_zero = near(space_dur, space_zero_us, noise_tolerance_us);

    cmd.is_read = (item.opcode == OP_READ);
    cmd.first   = item.first_of_capture;
    cmd.len_ok  = ({1'b0, item.capture_length} >= (LEN_W+1)'(FRAME_BYTES * 8));
    cmd.has_bit = space_found && !in_lead && (near_one || near_zero);
    cmd.bit_val = near_one;
  end

endmodule

// ----- rtl/core/pdfd_back.sv -----
// Back end: byte assembly, frame ring memory and frame readout sequencer.
// Depends on assert_macros.svh and pdfd_pkg.
`include "assert_macros.svh"

module pdfd_back
  import pdfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int RING_SLOTS  = RING_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_empty,
  input  cmd_t                           cmd,
  output logic                           cmd_pop,
  input  logic                           out_full,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_we,
  output out_item_t                      out_data
);

  localparam int DEPTH  = RING_SLOTS * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam int POS_W  = $clog2(FRAME_BYTES + 1);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [ADDR_W-1:0] wr_base;
  logic [ADDR_W-1:0] rd_base;
  logic [POS_W-1:0]  byte_pos;
  logic [8:0]        shifter;
  logic              cap_open;
  logic [POS_W-1:0]  rd_cnt;
  logic              rd_pend;
  logic              rd_last;
  logic [7:0]        mem_q;
  logic [7:0]        mem [DEPTH];

  logic              out_room;
  logic              cap_pop;
  logic              read_pop;
  logic              ring_empty;
  logic              open_eff;
  logic [POS_W-1:0]  pos_eff;
  logic [8:0]        shift_base;
  logic [8:0]        shift_next;
  logic              take_bit;
  logic              byte_done;
  logic              frame_done;
  logic [ADDR_W-1:0] mem_waddr;
  logic              issue;
  logic              issue_last;
  logic [ADDR_W-1:0] mem_raddr;

  always_comb begin
    out_room   = ((OCNT_W+1)'(out_count) + (OCNT_W+1)'(rd_pend)) < (OCNT_W+1)'(OUT_DEPTH);
    ring_empty = (read_slot == write_slot);
    cmd_pop    = (state == ST_IDLE) && !cmd_empty && (!cmd.is_read || (!rd_pend && out_room));
    cap_pop    = cmd_pop && !cmd.is_read;
    read_pop   = cmd_pop && cmd.is_read;

    // first item restarts assembly before its own bit lands
    open_eff   = cmd.first ? cmd.len_ok : cap_open;
    pos_eff    = cmd.first ? '0 : byte_pos;
    shift_base = cmd.first ? 9'd1 : shifter;
    shift_next = {shift_base[7:0], cmd.bit_val};
    take_bit   = cap_pop && open_eff && cmd.has_bit;
    byte_done  = take_bit && shift_next[8];
    frame_done = byte_done && (pos_eff == POS_W'(FRAME_BYTES - 1));
    mem_waddr  = wr_base + ADDR_W'(pos_eff);

    issue      = (state == ST_READ) && out_room;
    issue_last = (rd_cnt == POS_W'(FRAME_BYTES - 1));
    mem_raddr  = rd_base + ADDR_W'(rd_cnt);

    out_we   = rd_pend || (read_pop && ring_empty);
    out_data = '{frame_byte: 8'h00, frame_available: 1'b0, last_byte: 1'b1};
    if (rd_pend) begin
      out_data = '{frame_byte: mem_q, frame_available: 1'b1, last_byte: rd_last};
    end
  end

  always_ff @(posedge clk) begin
    if (byte_done) begin
      mem[mem_waddr] <= bit_reverse8(shift_next[7:0]);
    end
    if (issue) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      read_slot  <= '0;
      wr_base    <= '0;
      rd_base    <= '0;
      byte_pos   <= '0;
      shifter    <= 9'd1;
      cap_open   <= 1'b0;
      rd_cnt     <= '0;
      rd_pend    <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      rd_pend <= issue;
      rd_last <= issue && issue_last;
      if (cap_pop) begin
        cap_open <= open_eff && !frame_done;
        if (byte_done) begin
          shifter <= 9'd1;
        end else if (take_bit) begin
          shifter <= shift_next;
        end else begin
          shifter <= shift_base;
        end
        if (frame_done) begin
          byte_pos <= '0;
        end else if (byte_done) begin
          byte_pos <= pos_eff + 1'b1;
        end else begin
          byte_pos <= pos_eff;
        end
        if (frame_done) begin
          write_slot <= (write_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : write_slot + 1'b1;
          wr_base    <= (write_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 :
                        wr_base + ADDR_W'(FRAME_BYTES);
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (read_pop && !ring_empty) begin
            state  <= ST_READ;
            rd_cnt <= '0;
          end
        end
        ST_READ: begin
          if (issue) begin
            rd_cnt <= rd_cnt + 1'b1;
            if (issue_last) begin
              state     <= ST_IDLE;
              read_slot <= (read_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : read_slot + 1'b1;
              rd_base   <= (read_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 :
                           rd_base + ADDR_W'(FRAME_BYTES);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NOW(a_read_has_frame, clk, rst, state == ST_READ, read_slot != write_slot)
  `ASSERT_NOW(a_push_has_room, clk, rst, out_we, !out_full)
  `ASSERT_NOW(a_no_write_in_read, clk, rst, state == ST_READ, !byte_done)

endmodule

// ----- rtl/core/pulse_distance_frame_decoder.sv -----
// Top level of the pulse-distance frame decoder.
// Depends on assert_macros.svh, pdfd_pkg, pdfd_fifo, pdfd_front and pdfd_back.
//
// Usage:
//  - Input channel (push/full): capture items and frame read requests. An item
//    is taken on a clock edge with push high and full low. The front classifies
//    each item in the same cycle and drops it into a 4-beat command queue.
//  - Result channel (empty/pop): a 4-beat result queue. While empty is low the
//    oldest result sits on result; it leaves on an edge with pop high.
//  - Config channel (cfg_valid/cfg_ready): cfg_ready is always high; indexes
//    0..4 pick the space level and the four timing values, others are dropped.
//    Write only while the block is idle.
//  - Throughput: the back end retires one capture item per cycle while idle.
//    A frame read holds it from the request until its last byte is issued,
//    one byte per cycle while the result queue has room, through the single
//    read port of the ring memory; a following read waits for that byte's push.
//  - Read path: a request passes the command queue, address issue and memory
//    read before its first byte is queued; an empty ring skips issue and read.
//  - Stall: when pop stays low the result queue fills, byte issue pauses, the
//    command queue backs up and finally full rises. Nothing is dropped.
//  - Reset (rst, synchronous): queues empty, ring slots and assembly state
//    cleared, timing registers back to defaults. The ring memory itself is not
//    cleared; only fully written slots are ever read.
`include "assert_macros.svh"

module pulse_distance_frame_decoder
  import pdfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int RING_SLOTS  = RING_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             item,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data
);

  localparam int CMD_W  = $bits(cmd_t);
  localparam int OUT_W  = $bits(out_item_t);
  localparam int CCNT_W = $clog2(CMD_DEPTH + 1);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  cmd_t              cmd_in;
  logic [CMD_W-1:0]  cmd_q_bits;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [CCNT_W-1:0] cmd_count;

  logic              out_we;
  out_item_t         out_data;
  logic              out_full;
  logic [OCNT_W-1:0] out_count;
  logic [OUT_W-1:0]  result_bits;

  assign cfg_ready = 1'b1;
  assign result    = out_item_t'(result_bits);

  // front: config registers and classification
  pdfd_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd_in)
  );

  // decoupling queue between front and back
  pdfd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (CMD_W'(cmd_in)),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_q_bits),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  // back: assembly, ring memory, readout
  pdfd_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .RING_SLOTS  (RING_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_t'(cmd_q_bits)),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_count (out_count),
    .out_we    (out_we),
    .out_data  (out_data)
  );

  // result queue decouples readout from the receiver
  pdfd_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_we),
    .wr_data (OUT_W'(out_data)),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (result_bits),
    .empty   (empty),
    .count   (out_count)
  );

  `ASSERT_NOW(a_cmd_count_sane, clk, rst, cmd_pop, cmd_count != '0)

endmodule
